/* rtl/core/sst_pkg.sv */
`default_nettype none

package sst_pkg;

   // Action codes carried in a request beat.
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;
   localparam logic [1:0] ACT_OWNER  = 2'd3;

   // Status codes returned in a response beat.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_PRESENT = 3'd1;
   localparam logic [2:0] ST_ABSENT  = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  entity_id;
      logic [31:0] comp_word;
      logic [9:0]  dense_pos;
   } sst_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [31:0] data_out;
      logic [9:0]  owner_out;
      logic [9:0]  slot_out;
      logic [10:0] count_out;
   } sst_rsp_type;

endpackage

`default_nettype wire

/* rtl/core/sparse_set_table.sv */
// Add, owner_at and refused actions set their result strobe in S_MAP after start is taken;
// remove and lookup set it in S_FIX or S_DATA (map read, then a dense slot access or second
// map write). A new item is taken only once busy drops, set by the single write and
// read port of the entity map and of the dense slot memory; the receiver cannot stall.
// Reset: synchronous; afterwards busy stays high while a clearing pass marks every entity
// empty in the map memory.
`default_nettype none

module sparse_set_table
   import sst_pkg::*;
#(
   parameter int ENTITY_COUNT   = 1024,
   parameter int SLOT_COUNT     = 1024,
   parameter int COMPONENT_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire sst_req_type req_item,
   output logic             busy,
   output logic             rsp_strobe,
   output sst_rsp_type      rsp_item
);

   localparam int EAW = $clog2(ENTITY_COUNT);
   localparam int SAW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW  = $clog2(SLOT_COUNT + 1);
   localparam int MW  = SAW + 1;
   localparam int DW  = EAW + COMPONENT_BITS;

   localparam logic [CW-1:0]  SLOT_LIMIT = CW'(SLOT_COUNT);
   localparam logic [EAW-1:0] CLR_LAST   = EAW'(ENTITY_COUNT - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MAP,
      S_FIX,
      S_DATA
   } state_type;

   state_type      state_ff, state_in;
   logic [EAW-1:0] clr_ff, clr_in;
   logic [CW-1:0]  occ_ff, occ_in;
   logic           strobe_ff, strobe_in;
   sst_req_type    req_ff, req_in;
   sst_rsp_type    rsp_ff, rsp_in;

   // Entity map: valid bit on top of the dense slot index.
   logic [MW-1:0]  map_mem [ENTITY_COUNT];
   logic [MW-1:0]  map_rd_ff;
   logic           map_we, map_ren;
   logic [EAW-1:0] map_waddr, map_raddr;
   logic [MW-1:0]  map_wdata;

   // Dense slots: owner entity on top of the component word.
   logic [DW-1:0]  slot_mem [SLOT_COUNT];
   logic [DW-1:0]  slot_rd_ff;
   logic           slot_we, slot_ren;
   logic [SAW-1:0] slot_waddr, slot_raddr;
   logic [DW-1:0]  slot_wdata;

   logic [31:0]    ent_in_wide, ent_ff_wide, pos_in_wide, pos_ff_wide;
   logic [31:0]    occ_wide, last_wide, mslot_wide, owner_wide, cnt_wide, next_wide;
   logic [63:0]    word_wide, data_wide;
   logic [EAW-1:0] in_ent_idx, ff_ent_idx, moved_idx;
   logic [SAW-1:0] mslot, last_idx, pos_idx;
   logic           map_hit, ent_ok, pos_ok;
   sst_rsp_type    rsp_build;

   assign ent_in_wide = 32'(req_item.entity_id);
   assign ent_ff_wide = 32'(req_ff.entity_id);
   assign pos_in_wide = 32'(req_item.dense_pos);
   assign pos_ff_wide = 32'(req_ff.dense_pos);
   assign in_ent_idx  = ent_in_wide[EAW-1:0];
   assign ff_ent_idx  = ent_ff_wide[EAW-1:0];
   assign pos_idx     = pos_in_wide[SAW-1:0];
   assign occ_wide    = 32'(occ_ff);
   assign last_wide   = occ_wide - 32'd1;
   assign last_idx    = last_wide[SAW-1:0];
   assign next_wide   = occ_wide;

   assign map_hit     = map_rd_ff[SAW];
   assign mslot       = map_rd_ff[SAW-1:0];
   assign mslot_wide  = 32'(mslot);
   assign moved_idx   = slot_rd_ff[DW-1:COMPONENT_BITS];
   assign owner_wide  = 32'(moved_idx);
   assign data_wide   = 64'(slot_rd_ff[COMPONENT_BITS-1:0]);
   assign word_wide   = 64'(req_ff.comp_word);

   assign ent_ok      = ent_ff_wide < 32'(ENTITY_COUNT);
   // The occupied count never exceeds the slot count, so this also bounds the position.
   assign pos_ok      = pos_ff_wide < occ_wide;

   assign map_raddr   = in_ent_idx;
   assign map_ren     = (state_ff == S_IDLE);
   assign slot_ren    = (state_ff == S_IDLE) || (state_ff == S_MAP);

   always_comb begin
      if (state_ff == S_IDLE) begin
         slot_raddr = (req_item.action == ACT_OWNER) ? pos_idx : last_idx;
      end else begin
         slot_raddr = mslot;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      occ_in     = occ_ff;
      strobe_in  = 1'b0;
      req_in     = req_ff;
      rsp_in     = rsp_ff;
      rsp_build  = '0;
      map_we     = 1'b0;
      map_waddr  = ff_ent_idx;
      map_wdata  = '0;
      slot_we    = 1'b0;
      slot_waddr = mslot;
      slot_wdata = slot_rd_ff;
      cnt_wide   = '0;

      case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            clr_in    = clr_ff + EAW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            if (req_ff.action == ACT_OWNER) begin
               if (pos_ok) begin
                  rsp_build.owner_out = owner_wide[9:0];
               end else begin
                  rsp_build.status = ST_RANGE;
               end
            end else if (!ent_ok) begin
               rsp_build.status = ST_RANGE;
            end else begin
               rsp_build.found = map_hit;
               case (req_ff.action)
                  ACT_ADD: begin
                     if (map_hit) begin
                        rsp_build.status   = ST_PRESENT;
                        rsp_build.slot_out = mslot_wide[9:0];
                     end else if (occ_ff == SLOT_LIMIT) begin
                        rsp_build.status = ST_FULL;
                     end else begin
                        slot_we            = 1'b1;
                        slot_waddr         = next_wide[SAW-1:0];
                        slot_wdata         = {ff_ent_idx, word_wide[COMPONENT_BITS-1:0]};
                        map_we             = 1'b1;
                        map_waddr          = ff_ent_idx;
                        map_wdata          = {1'b1, next_wide[SAW-1:0]};
                        occ_in             = occ_ff + CW'(1);
                        rsp_build.slot_out = next_wide[9:0];
                     end
                  end
                  ACT_REMOVE: begin
                     if (!map_hit || occ_ff == '0) begin
                        rsp_build.status = ST_ABSENT;
                     end else begin
                        occ_in = occ_ff - CW'(1);
                        // Fill the hole with the last slot and repoint its owner;
                        // the removed entity's map entry is cleared next cycle.
                        if (mslot != last_idx) begin
                           slot_we    = 1'b1;
                           slot_waddr = mslot;
                           slot_wdata = slot_rd_ff;
                           map_we     = 1'b1;
                           map_waddr  = moved_idx;
                           map_wdata  = {1'b1, mslot};
                        end
                        strobe_in = 1'b0;
                        state_in  = S_FIX;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (!map_hit) begin
                        rsp_build.status = ST_ABSENT;
                     end else begin
                        rsp_build.slot_out = mslot_wide[9:0];
                        strobe_in          = 1'b0;
                        state_in           = S_DATA;
                     end
                  end
                  default: begin
                     rsp_build.status = ST_RANGE;
                  end
               endcase
            end
            cnt_wide            = 32'(occ_in);
            rsp_build.count_out = cnt_wide[10:0];
            rsp_in              = rsp_build;
         end
         S_FIX: begin
            map_we    = 1'b1;
            map_waddr = ff_ent_idx;
            map_wdata = '0;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_DATA: begin
            rsp_in.data_out = data_wide[31:0];
            strobe_in       = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         occ_ff    <= occ_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      if (map_ren) begin
         map_rd_ff <= map_mem[map_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_ren) begin
         slot_rd_ff <= slot_mem[slot_raddr];
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire
